// ===== hdl/plbp_pkg.sv =====
// ----------------------------------------------------------------------------
// plbp_pkg: shared types and constants of the per-label brightest point block
// Word layouts for both stream channels, opcodes, register map and defaults.
// ----------------------------------------------------------------------------
package plbp_pkg;

  // Field widths fixed by the stream format
  localparam int LABEL_W         = 8;
  localparam int CHAN_W          = 8;
  localparam int OUT_COORD_W     = 12;
  localparam int FRAME_WIDTH_W   = 13;
  localparam int APB_ADDR_W      = 3;
  localparam int APB_DATA_W      = 32;

  // Defaults for the top-level parameters
  localparam int LABEL_COUNT_DEF = 256;
  localparam int COORD_BITS_DEF  = 12;

  // Reset value of the frame width register
  localparam logic [FRAME_WIDTH_W-1:0] FRAME_WIDTH_RST = 13'd640;

  // Register map: word index taken from paddr[2]
  localparam logic REG_FRAME_WIDTH = 1'b0;

  // Input word opcodes
  typedef enum logic [1:0] {
    OP_PIXEL = 2'd0,
    OP_QUERY = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  // Input word
  typedef struct packed {
    logic [1:0]         operation;
    logic [LABEL_W-1:0] label;
    logic [CHAN_W-1:0]  brightness;
    logic [CHAN_W-1:0]  saturation;
  } in_item_t;

  // Result word
  typedef struct packed {
    logic                   found;
    logic [OUT_COORD_W-1:0] best_column;
    logic [OUT_COORD_W-1:0] best_row;
    logic [LABEL_W-1:0]     highest_label;
  } out_item_t;

  // Controller to datapath commands
  typedef struct packed {
    logic accept;    // capture input word, start table read
    logic clear;     // start a new frame
    logic update;    // pixel compare, table write, position advance
    logic load_out;  // load the result register from the query
  } plbp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic out_blocked;  // result register full and not drained this cycle
  } plbp_sts_t;

endpackage

// ===== hdl/per_label_brightest_point.sv =====
// ----------------------------------------------------------------------------
// per_label_brightest_point: brightest, least saturated pixel per label
// Top level: APB register, sequencer and datapath.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid_i / in_ready_o / in_item_i) carries one word
//   per pixel, query or clear. Pixels arrive in raster order; the column
//   counter wraps at frame_width, clamped to 1..2**COORD_BITS (APB register
//   at byte address 0). A pixel word reads the label table when it is
//   accepted and is compared and written back in the update step. The
//   single-port label table serves both, so no new word is accepted until
//   that write-back is done. A clear or an ignored word ends on acceptance.
//   A query yields one result word on the output channel (out_valid_o /
//   out_ready_i / out_item_o); its reply step loads it into an output
//   register, so later pixels are accepted while it waits.
//   A second query stalls in its reply step until that register drains.
//   Reset clears seen flags, position counters, largest label and sets the
//   frame width to 640; table contents need no clearing.
// ----------------------------------------------------------------------------
module per_label_brightest_point #(
  parameter int LABEL_COUNT = plbp_pkg::LABEL_COUNT_DEF,
  parameter int COORD_BITS  = plbp_pkg::COORD_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // input stream
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  plbp_pkg::in_item_t                in_item_i,
  // result stream
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output plbp_pkg::out_item_t               out_item_o,
  // APB register port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [plbp_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [plbp_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [plbp_pkg::APB_DATA_W-1:0]   prdata,
  output logic                              pready
);
  import plbp_pkg::*;

  logic [FRAME_WIDTH_W-1:0] frame_width_q;
  plbp_cmd_t                cmd;
  plbp_sts_t                sts;

  // APB register file
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_FRAME_WIDTH) ? APB_DATA_W'(frame_width_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q <= FRAME_WIDTH_RST;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_FRAME_WIDTH)) begin
      frame_width_q <= pwdata[FRAME_WIDTH_W-1:0];
    end
  end

  plbp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_op_i    (in_item_i.operation),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  plbp_dp #(
    .LABEL_COUNT (LABEL_COUNT),
    .COORD_BITS  (COORD_BITS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .in_item_i     (in_item_i),
    .frame_width_i (frame_width_q),
    .out_item_o    (out_item_o),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i)
  );

endmodule

// ===== hdl/plbp_ctrl.sv =====
// ----------------------------------------------------------------------------
// plbp_ctrl: sequencer of the per-label brightest point block
// Steps each input word through table read, update or reply.
// ----------------------------------------------------------------------------
module plbp_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic [1:0]          in_op_i,
  output logic                in_ready_o,
  input  plbp_pkg::plbp_sts_t sts_i,
  output plbp_pkg::plbp_cmd_t cmd_o
);
  import plbp_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_UPDATE = 3'b010,
    S_REPLY  = 3'b100
  } state_e;

  state_e state_q, state_d;

  // Next state and command decode
  always_comb begin
    state_d        = state_q;
    cmd_o          = '0;
    in_ready_o     = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          unique case (op_e'(in_op_i))
            OP_PIXEL: state_d = S_UPDATE;
            OP_QUERY: state_d = S_REPLY;
            OP_CLEAR: cmd_o.clear = 1'b1;
            OP_NONE:  state_d = S_IDLE;
          endcase
        end
      end
      S_UPDATE: begin
        cmd_o.update = 1'b1;
        state_d      = S_IDLE;
      end
      S_REPLY: begin
        // wait for room in the result register
        if (!sts_i.out_blocked) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== hdl/plbp_dp.sv =====
// ----------------------------------------------------------------------------
// plbp_dp: datapath of the per-label brightest point block
// Label table, seen flags, position counters and the result register.
// ----------------------------------------------------------------------------
module plbp_dp #(
  parameter int LABEL_COUNT = plbp_pkg::LABEL_COUNT_DEF,
  parameter int COORD_BITS  = plbp_pkg::COORD_BITS_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  plbp_pkg::plbp_cmd_t                   cmd_i,
  output plbp_pkg::plbp_sts_t                   sts_o,
  input  plbp_pkg::in_item_t                    in_item_i,
  input  logic [plbp_pkg::FRAME_WIDTH_W-1:0]    frame_width_i,
  output plbp_pkg::out_item_t                   out_item_o,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i
);
  import plbp_pkg::*;

  localparam int IDX_W   = $clog2(LABEL_COUNT);
  localparam int ENTRY_W = 2 * CHAN_W + 2 * COORD_BITS;
  localparam int CMP_W   = (COORD_BITS + 1 > FRAME_WIDTH_W) ? COORD_BITS + 1 : FRAME_WIDTH_W;
  localparam logic [LABEL_W:0]  LBL_LIMIT = (LABEL_W + 1)'(LABEL_COUNT);
  localparam logic [CMP_W-1:0]  WIDTH_MAX = CMP_W'(2 ** COORD_BITS);

  // Captured word
  logic [LABEL_W-1:0] label_q;
  logic [CHAN_W-1:0]  bright_q;
  logic [CHAN_W-1:0]  sat_q;

  // Table: brightness, saturation, column, row per label
  logic [ENTRY_W-1:0] table_mem [LABEL_COUNT];
  logic [ENTRY_W-1:0] rd_q;
  logic [LABEL_COUNT-1:0] seen_q;

  logic [COORD_BITS-1:0] col_q, col_d;
  logic [COORD_BITS-1:0] row_q, row_d;
  logic [LABEL_W-1:0]    largest_q;

  out_item_t out_q;
  logic      out_valid_q;

  logic [IDX_W-1:0]      idx;
  logic                  tracked;
  logic                  take;
  logic                  hit;
  logic [CHAN_W-1:0]     rd_bright;
  logic [CHAN_W-1:0]     rd_sat;
  logic [COORD_BITS-1:0] rd_col;
  logic [COORD_BITS-1:0] rd_row;
  logic [CMP_W-1:0]      fw_ext;
  logic [CMP_W-1:0]      eff_width;
  logic [CMP_W-1:0]      col_inc;
  logic                  wrap;

  assign idx       = label_q[IDX_W-1:0];
  assign tracked   = (label_q != '0) && ({1'b0, label_q} < LBL_LIMIT);
  assign rd_bright = rd_q[ENTRY_W-1 -: CHAN_W];
  assign rd_sat    = rd_q[ENTRY_W-CHAN_W-1 -: CHAN_W];
  assign rd_col    = rd_q[2*COORD_BITS-1 -: COORD_BITS];
  assign rd_row    = rd_q[COORD_BITS-1:0];

  // Keep rule: first hit, brighter, or equally bright and less saturated
  assign take = tracked && (!seen_q[idx] || (bright_q > rd_bright) ||
                            ((bright_q == rd_bright) && (sat_q < rd_sat)));
  assign hit  = tracked && seen_q[idx];

  // Raster position advance with clamped frame width
  always_comb begin
    fw_ext = CMP_W'(frame_width_i);
    if (fw_ext == '0) begin
      eff_width = CMP_W'(1);
    end else if (fw_ext > WIDTH_MAX) begin
      eff_width = WIDTH_MAX;
    end else begin
      eff_width = fw_ext;
    end
    col_inc = CMP_W'(col_q) + CMP_W'(1);
    wrap    = (col_inc >= eff_width);
    col_d   = wrap ? '0 : col_q + COORD_BITS'(1);
    row_d   = wrap ? row_q + COORD_BITS'(1) : row_q;
  end

  // Word capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      label_q  <= in_item_i.label;
      bright_q <= in_item_i.brightness;
      sat_q    <= in_item_i.saturation;
    end
  end

  // Table port: read on accept, write on a kept pixel
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      rd_q <= table_mem[in_item_i.label[IDX_W-1:0]];
    end
    if (cmd_i.update && take) begin
      table_mem[idx] <= {bright_q, sat_q, col_q, row_q};
    end
  end

  // Frame state: seen flags, counters, largest label
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q    <= '0;
      col_q     <= '0;
      row_q     <= '0;
      largest_q <= '0;
    end else if (cmd_i.clear) begin
      seen_q    <= '0;
      col_q     <= '0;
      row_q     <= '0;
      largest_q <= '0;
    end else if (cmd_i.update) begin
      col_q <= col_d;
      row_q <= row_d;
      if (take) begin
        seen_q[idx] <= 1'b1;
      end
      if (tracked && (label_q > largest_q)) begin
        largest_q <= label_q;
      end
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_q.found         <= hit;
      out_q.best_column   <= hit ? OUT_COORD_W'(rd_col) : '0;
      out_q.best_row      <= hit ? OUT_COORD_W'(rd_row) : '0;
      out_q.highest_label <= largest_q;
    end
  end

  assign out_item_o        = out_q;
  assign out_valid_o       = out_valid_q;
  assign sts_o.out_blocked = out_valid_q && !out_ready_i;

  // Checks
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_out |-> !(out_valid_q && !out_ready_i))
    else $error("result loaded over an undelivered word");

  a_clear_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.clear |=> (seen_q == '0) && (largest_q == '0) && (col_q == '0))
    else $error("clear left frame state behind");

  a_largest_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cmd_i.clear |=> largest_q >= $past(largest_q))
    else $error("largest label shrank without a clear");

  a_take_marks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.update && take) |=> seen_q[$past(idx)])
    else $error("kept pixel did not mark its label seen");

endmodule

// ===== tb/per_label_brightest_point_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// per_label_brightest_point_tb: self-checking bench of the brightest point block
// Streams pixel, query, clear and ignored words with random gaps on both sides.
// A local tracker of label table and raster position predicts the answers
// of untyped queries; the frame width is reprogrammed over APB between phases.
// ----------------------------------------------------------------------------
module per_label_brightest_point_tb;
  import plbp_pkg::*;

  localparam int LABELS = LABEL_COUNT_DEF;
  localparam int COORD_SPAN = 1 << COORD_BITS_DEF;
  localparam int SETTLE = 4;  // settling wait for a pixel still in flight
  localparam logic [APB_ADDR_W-1:0] FW_ADDR = {REG_FRAME_WIDTH, 2'b00};

  // Directed row: word, whether the answer is typed in, and that answer
  typedef struct packed {
    in_item_t  word;
    logic      typed;
    out_item_t point;
  } row_t;

  localparam int DIRECTED_ROWS = 24;
  localparam row_t DIRECTED[DIRECTED_ROWS] = '{
    // empty table after reset, background and ignored words
    '{'{OP_QUERY, 8'd5,   8'd0,   8'd0},   1'b1, '{1'b0, 12'd0, 12'd0, 8'd0}},
    '{'{OP_QUERY, 8'd0,   8'd0,   8'd0},   1'b1, '{1'b0, 12'd0, 12'd0, 8'd0}},
    '{'{OP_NONE,  8'd255, 8'd255, 8'd255}, 1'b0, '0},
    '{'{OP_QUERY, 8'd255, 8'd0,   8'd0},   1'b1, '{1'b0, 12'd0, 12'd0, 8'd0}},
    '{'{OP_PIXEL, 8'd0,   8'd255, 8'd0},   1'b0, '0},
    '{'{OP_QUERY, 8'd0,   8'd0,   8'd0},   1'b1, '{1'b0, 12'd0, 12'd0, 8'd0}},
    // first pixel of a label is always taken
    '{'{OP_PIXEL, 8'd255, 8'd0,   8'd255}, 1'b0, '0},
    '{'{OP_QUERY, 8'd255, 8'd0,   8'd0},   1'b1, '{1'b1, 12'd1, 12'd0, 8'd255}},
    // full tie keeps first, lower saturation wins
    '{'{OP_PIXEL, 8'd255, 8'd0,   8'd255}, 1'b0, '0},
    '{'{OP_PIXEL, 8'd255, 8'd0,   8'd254}, 1'b0, '0},
    '{'{OP_QUERY, 8'd255, 8'd0,   8'd0},   1'b0, '0},
    // brighter pixel resets saturation
    '{'{OP_PIXEL, 8'd255, 8'd1,   8'd255}, 1'b0, '0},
    '{'{OP_PIXEL, 8'd255, 8'd1,   8'd254}, 1'b0, '0},
    '{'{OP_PIXEL, 8'd255, 8'd255, 8'd255}, 1'b0, '0},
    '{'{OP_PIXEL, 8'd255, 8'd254, 8'd0},   1'b0, '0},
    '{'{OP_PIXEL, 8'd255, 8'd255, 8'd255}, 1'b0, '0},
    '{'{OP_QUERY, 8'd255, 8'd0,   8'd0},   1'b0, '0},
    '{'{OP_PIXEL, 8'd1,   8'd128, 8'd128}, 1'b0, '0},
    '{'{OP_QUERY, 8'd1,   8'd0,   8'd0},   1'b0, '0},
    // clear restarts table and counters
    '{'{OP_CLEAR, 8'd0,   8'd0,   8'd0},   1'b0, '0},
    '{'{OP_QUERY, 8'd255, 8'd0,   8'd0},   1'b1, '{1'b0, 12'd0, 12'd0, 8'd0}},
    '{'{OP_PIXEL, 8'd1,   8'd0,   8'd0},   1'b0, '0},
    '{'{OP_QUERY, 8'd1,   8'd0,   8'd0},   1'b1, '{1'b1, 12'd0, 12'd0, 8'd1}},
    '{'{OP_NONE,  8'd0,   8'd0,   8'd0},   1'b0, '0}
  };

  logic                  clk_i;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_ready_o;
  in_item_t              in_item_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  out_item_t             out_item_o;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  per_label_brightest_point uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  // Tracked copy of the label table and raster position
  bit                   lbl_seen [LABELS];
  bit [CHAN_W-1:0]      lbl_peak [LABELS];
  bit [CHAN_W-1:0]      lbl_sat  [LABELS];
  bit [OUT_COORD_W-1:0] lbl_col  [LABELS];
  bit [OUT_COORD_W-1:0] lbl_row  [LABELS];
  bit [OUT_COORD_W-1:0] pos_col;
  bit [OUT_COORD_W-1:0] pos_row;
  bit [LABEL_W-1:0]     top_label;
  int                   width_setting;

  out_item_t        pending_points[$];
  int               errors;
  bit               idle_on;
  bit               stall_on;
  bit [LABEL_W-1:0] label_pool[4];

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Run limit
  initial begin
    #3_000_000;
    $display("FAILURE");
    $finish;
  end

  // New frame: forget labels, restart position
  function automatic void restart_frame();
    foreach (lbl_seen[i]) lbl_seen[i] = 1'b0;
    pos_col = '0;
    pos_row = '0;
    top_label = '0;
  endfunction

  // Tracks one word; returns 1 with the answer when the word is a query
  function automatic bit predict_point(input in_item_t w, output out_item_t p);
    int  eff;
    bit  take;
    int  l;
    l = w.label;
    p = '0;
    case (op_e'(w.operation))
      OP_PIXEL: begin
        if (l != 0) begin
          if (w.label > top_label) top_label = w.label;
          take = !lbl_seen[l] || w.brightness > lbl_peak[l] ||
                 (w.brightness == lbl_peak[l] && w.saturation < lbl_sat[l]);
          if (take) begin
            lbl_seen[l] = 1'b1;
            lbl_peak[l] = w.brightness;
            lbl_sat[l]  = w.saturation;
            lbl_col[l]  = pos_col;
            lbl_row[l]  = pos_row;
          end
        end
        // zero width acts as one, oversized width saturates at the coord span
        eff = (width_setting == 0) ? 1 :
              (width_setting > COORD_SPAN) ? COORD_SPAN : width_setting;
        if (int'(pos_col) + 1 >= eff) begin
          pos_col = '0;
          pos_row = pos_row + 1'b1;
        end else begin
          pos_col = pos_col + 1'b1;
        end
        return 1'b0;
      end
      OP_QUERY: begin
        if (l != 0 && lbl_seen[l]) begin
          p.found       = 1'b1;
          p.best_column = lbl_col[l];
          p.best_row    = lbl_row[l];
        end
        p.highest_label = top_label;
        return 1'b1;
      end
      OP_CLEAR: begin
        restart_frame();
        return 1'b0;
      end
      default: return 1'b0;
    endcase
  endfunction

  // Present one word, wait for its handshake, then log its answer
  task automatic send_word(input in_item_t w, input bit typed, input out_item_t typed_point);
    int        gap;
    bit        hs;
    out_item_t p;
    gap = idle_on ? $urandom_range(0, 9) : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= w;
    do begin
      @(negedge clk_i);
      hs = in_ready_o;
      @(posedge clk_i);
    end while (!hs);
    if (predict_point(w, p)) pending_points = {pending_points, (typed ? typed_point : p)};
  endtask

  // Idle the input and let every answer come out
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (pending_points.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // One APB transfer: setup, then access until pready
  task automatic reg_access(input bit wr, input logic [APB_DATA_W-1:0] wdata,
                            output logic [APB_DATA_W-1:0] rdata);
    bit rdy;
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= FW_ADDR;
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do begin
      @(negedge clk_i);
      rdy   = pready;
      rdata = prdata;
      @(posedge clk_i);
    end while (!rdy);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic verify_frame_width(input logic [FRAME_WIDTH_W-1:0] want);
    logic [APB_DATA_W-1:0] rd;
    reg_access(1'b0, '0, rd);
    if (rd[FRAME_WIDTH_W-1:0] !== want) begin
      $error("frame_width: expected %0d, actual %0d", want, rd[FRAME_WIDTH_W-1:0]);
      errors++;
    end
  endtask

  task automatic set_frame_width(input int value);
    logic [APB_DATA_W-1:0] rd;
    drain_results();
    reg_access(1'b1, APB_DATA_W'(value), rd);
    width_setting = value;
    verify_frame_width(FRAME_WIDTH_W'(value));
  endtask

  // Mostly pixels on a few labels, with ties likely; sweeps are near pure pixels
  function automatic in_item_t random_word(input bit sweep);
    in_item_t w;
    int       r;
    w = in_item_t'($urandom);
    r = $urandom_range(0, 99);
    if (r < (sweep ? 94 : 60)) begin
      w.operation = OP_PIXEL;
      if ($urandom_range(0, 99) < 85) w.label = label_pool[$urandom_range(0, 3)];
      if ($urandom_range(0, 1)) w.brightness = CHAN_W'($urandom_range(252, 255));
      if ($urandom_range(0, 1)) w.saturation = CHAN_W'($urandom_range(0, 3));
    end else if (r < (sweep ? 100 : 88)) begin
      w.operation = OP_QUERY;
      if ($urandom_range(0, 99) < 80) w.label = label_pool[$urandom_range(0, 3)];
    end else if (r < 94) begin
      w.operation = OP_CLEAR;
    end else begin
      w.operation = OP_NONE;
    end
    return w;
  endfunction

  // Result side: random stalls, then compare against the oldest answer
  initial begin
    int        stall;
    bit        took;
    out_item_t got;
    out_item_t want;
    out_ready_i <= 1'b0;
    @(posedge clk_i);
    forever begin
      stall = stall_on ? $urandom_range(0, 9) : 0;
      if (stall != 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do begin
        @(negedge clk_i);
        took = out_valid_o && out_ready_i;
        got  = out_item_o;
        @(posedge clk_i);
      end while (!took);
      if (pending_points.size() == 0) begin
        $error("unexpected result word %h", got);
        errors++;
      end else begin
        want = pending_points.pop_front();
        if (got.found !== want.found) begin
          $error("found: expected %0d, actual %0d", want.found, got.found);
          errors++;
        end
        if (got.best_column !== want.best_column) begin
          $error("best_column: expected %0d, actual %0d", want.best_column, got.best_column);
          errors++;
        end
        if (got.best_row !== want.best_row) begin
          $error("best_row: expected %0d, actual %0d", want.best_row, got.best_row);
          errors++;
        end
        if (got.highest_label !== want.highest_label) begin
          $error("highest_label: expected %0d, actual %0d",
                 want.highest_label, got.highest_label);
          errors++;
        end
      end
    end
  end

  // Stimulus
  initial begin
    int phase_width;
    int phase_items;
    bit sweep;
    errors        = 0;
    idle_on       = 1'b1;
    stall_on      = 1'b1;
    width_setting = int'(FRAME_WIDTH_RST);
    restart_frame();
    rst_ni     <= 1'b0;
    in_valid_i <= 1'b0;
    in_item_i  <= '0;
    psel       <= 1'b0;
    penable    <= 1'b0;
    pwrite     <= 1'b0;
    paddr      <= '0;
    pwdata     <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    verify_frame_width(FRAME_WIDTH_RST);

    // Directed rows at the reset width
    foreach (DIRECTED[i]) send_word(DIRECTED[i].word, DIRECTED[i].typed, DIRECTED[i].point);

    // Random phases over several widths; two of them are pixel-heavy sweeps
    for (int ph = 0; ph < 8; ph++) begin
      sweep = 1'b0;
      phase_items = 140;
      case (ph)
        0: phase_width = 1;
        1: phase_width = 0;
        2: phase_width = COORD_SPAN;
        3: begin
          phase_width = (1 << FRAME_WIDTH_W) - 1;
          sweep = 1'b1;
        end
        4: phase_width = $urandom_range(2, 16);
        5: phase_width = $urandom_range(17, COORD_SPAN - 1);
        6: begin
          phase_width = 1;
          sweep = 1'b1;
        end
        default: phase_width = int'(FRAME_WIDTH_RST);
      endcase
      set_frame_width(phase_width);
      idle_on  = (ph % 3) != 2;
      stall_on = (ph % 4) != 1;
      label_pool[0] = LABEL_W'($urandom_range(1, 255));
      label_pool[1] = LABEL_W'($urandom_range(1, 255));
      label_pool[2] = (ph % 2) ? 8'd255 : 8'd1;
      label_pool[3] = 8'd0;
      // each phase starts from a fresh frame
      send_word('{OP_CLEAR, 8'd0, 8'd0, 8'd0}, 1'b0, '0);
      repeat (phase_items) send_word(random_word(sweep), 1'b0, '0);
    end

    drain_results();
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
